>>> rtl/core/sfhb_pkg.sv
// ----------------------------------------------------------------------------
// sfhb_pkg
// Shared constants, types and mixing functions for the blocked hash unit.
// ----------------------------------------------------------------------------
package sfhb_pkg;

  localparam int BLOCK_BYTES = 65536;
  localparam int CNT_W       = $clog2(BLOCK_BYTES);
  localparam logic [CNT_W-1:0] BLOCK_LAST = CNT_W'(BLOCK_BYTES - 1);

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [31:0] hash;
    logic [23:0] word;
    logic [1:0]  count;
  } fin_entry_t;

  typedef struct packed {
    logic        valid;
    logic        wb;
    logic        last;
    logic [31:0] hash;
  } fin_done_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] a;
    logic [31:0] t;
    logic [31:0] m;
    a = h + {16'd0, w[15:0]};
    t = {5'd0, w[31:16], 11'd0} ^ a;
    m = {a[15:0], 16'd0} ^ t;
    return m + (m >> 11);
  endfunction

  function automatic logic [31:0] mix_tail(input logic [31:0] h, input logic [23:0] w,
                                           input logic [1:0] n);
    logic [31:0] a;
    logic [31:0] m;
    a = h;
    m = h;
    case (n)
      2'd3: begin
        a = h + {16'd0, w[15:0]};
        m = a ^ {a[15:0], 16'd0};
        m = m ^ {{6{w[23]}}, w[23:16], 18'd0};
        m = m + (m >> 11);
      end
      2'd2: begin
        a = h + {16'd0, w[15:0]};
        m = a ^ {a[20:0], 11'd0};
        m = m + (m >> 17);
      end
      2'd1: begin
        a = h + sext8(w[7:0]);
        m = a ^ {a[21:0], 10'd0};
        m = m + (m >> 1);
      end
      default: m = h;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] aval_front(input logic [31:0] h);
    logic [31:0] m;
    m = h ^ {h[28:0], 3'd0};
    m = m + (m >> 5);
    m = m ^ {m[27:0], 4'd0};
    return m + (m >> 17);
  endfunction

  function automatic logic [31:0] aval_back(input logic [31:0] h);
    logic [31:0] m;
    m = h ^ {h[6:0], 25'd0};
    return m + (m >> 6);
  endfunction

endpackage

>>> rtl/core/sfhb_finish.sv
// ----------------------------------------------------------------------------
// sfhb_finish
// Three-stage pipeline that mixes the tail of a block and runs the avalanche.
// ----------------------------------------------------------------------------
module sfhb_finish (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                kill,
  input  sfhb_pkg::fin_entry_t entry,
  output logic                pend,
  output sfhb_pkg::fin_done_t done
);

  logic        f1_valid;
  logic        f1_wb;
  logic        f1_last;
  logic [31:0] f1_hash;
  logic [23:0] f1_word;
  logic [1:0]  f1_count;
  logic        f2_valid;
  logic        f2_wb;
  logic        f2_last;
  logic [31:0] f2_hash;
  logic        f3_valid;
  logic        f3_wb;
  logic        f3_last;
  logic [31:0] f3_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f1_wb    <= 1'b0;
      f2_wb    <= 1'b0;
      f3_wb    <= 1'b0;
    end else if (adv) begin
      f1_valid <= entry.valid;
      f1_wb    <= entry.valid;
      f2_valid <= f1_valid;
      f2_wb    <= f1_wb && !kill;
      f3_valid <= f2_valid;
      f3_wb    <= f2_wb && !kill;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_last  <= entry.last;
      f1_hash  <= entry.hash;
      f1_word  <= entry.word;
      f1_count <= entry.count;
      f2_last  <= f1_last;
      f2_hash  <= sfhb_pkg::mix_tail(f1_hash, f1_word, f1_count);
      f3_last  <= f2_last;
      f3_hash  <= sfhb_pkg::aval_front(f2_hash);
    end
  end

  assign pend = (f1_valid && f1_wb) || (f2_valid && f2_wb) || (f3_valid && f3_wb);

  always_comb begin
    done.valid = f3_valid;
    done.wb    = f3_wb;
    done.last  = f3_last;
    done.hash  = sfhb_pkg::aval_back(f3_hash);
  end

endmodule

>>> rtl/core/super_fast_hash_blocked_unit.sv
// ----------------------------------------------------------------------------
// super_fast_hash_blocked_unit
// Byte-stream hash with per-block avalanche, one byte accepted per cycle while not stalled.
// ----------------------------------------------------------------------------
// The unit takes one message byte per cycle and presents the 32-bit hash once
// the last byte of a message has passed the input stage, the finish stages
// and the output register. Each fourth byte runs one mixing round in the input
// stage; the tail mix and avalanche then pass through a three-stage pipeline
// whose result becomes the running hash. A byte that ends a message or a
// block, or would mix a word, while that result is still in the pipeline and
// the byte does not start a new message, waits for it, so the rate is one byte
// per cycle apart from those cases and any stall on the result side.
module super_fast_hash_blocked_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [30:0] message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);

  logic                      s0_valid;
  logic [7:0]                s0_byte;
  logic                      s0_first;
  logic                      s0_last;
  logic [30:0]               s0_length;
  logic [31:0]               running_hash;
  logic [23:0]               partial_word;
  logic [1:0]                byte_in_word;
  logic [sfhb_pkg::CNT_W-1:0] block_byte_count;
  logic [31:0]               hash_eff;
  logic [23:0]               word_eff;
  logic [1:0]                pos_eff;
  logic [sfhb_pkg::CNT_W-1:0] count_eff;
  logic [31:0]               hash_next;
  logic [23:0]               word_next;
  logic [1:0]                pos_next;
  logic                      s0_end;
  logic                      s0_hazard;
  logic                      s0_go;
  logic                      adv;
  logic                      kill;
  logic                      pend;
  logic                      wb_now;
  sfhb_pkg::fin_entry_t      entry;
  sfhb_pkg::fin_done_t       done;

  assign adv       = !(done.valid && done.last && out_valid && out_stall);
  assign s0_hazard = !s0_first && pend && (s0_last || s0_end || byte_in_word == 2'd3);
  assign s0_go     = s0_valid && adv && !s0_hazard;
  assign in_stall  = s0_valid && !s0_go;
  assign kill      = s0_go && s0_first;
  assign wb_now    = adv && done.valid && done.wb && !kill;

  always_comb begin
    if (s0_first) begin
      hash_eff  = {1'b0, s0_length};
      word_eff  = '0;
      pos_eff   = '0;
      count_eff = '0;
    end else begin
      hash_eff  = running_hash;
      word_eff  = partial_word;
      pos_eff   = byte_in_word;
      count_eff = block_byte_count;
    end
    hash_next = hash_eff;
    word_next = word_eff;
    pos_next  = pos_eff + 2'd1;
    case (pos_eff)
      2'd0: word_next[7:0]   = s0_byte;
      2'd1: word_next[15:8]  = s0_byte;
      2'd2: word_next[23:16] = s0_byte;
      default: begin
        hash_next = sfhb_pkg::mix_word(hash_eff, {s0_byte, word_eff});
        word_next = '0;
      end
    endcase
    s0_end = s0_last || (count_eff == sfhb_pkg::BLOCK_LAST);
  end

  always_comb begin
    entry.valid = s0_go && s0_end;
    entry.last  = s0_last;
    entry.hash  = hash_next;
    entry.word  = word_next;
    entry.count = pos_next;
  end

  sfhb_finish u_finish (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .kill  (kill),
    .entry (entry),
    .pend  (pend),
    .done  (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!in_stall) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_byte   <= data_byte;
      s0_first  <= first_byte;
      s0_last   <= last_byte;
      s0_length <= message_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash     <= '0;
      partial_word     <= '0;
      byte_in_word     <= '0;
      block_byte_count <= '0;
    end else begin
      if (wb_now) begin
        running_hash <= done.hash;
      end else if (s0_go) begin
        running_hash <= hash_next;
      end
      if (s0_go) begin
        if (s0_end) begin
          partial_word     <= '0;
          byte_in_word     <= '0;
          block_byte_count <= '0;
        end else begin
          partial_word     <= word_next;
          byte_in_word     <= pos_next;
          block_byte_count <= count_eff + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && done.valid && done.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && done.valid && done.last) begin
      hash_value <= done.hash;
    end
  end

`ifndef SYNTHESIS
  a_word_mix_clear: assert property (@(posedge clk) disable iff (rst)
    s0_go && !s0_first && byte_in_word == 2'd3 |-> !pend)
    else $error("word mixed while a block result was pending");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s0_go && s0_end |=> byte_in_word == 2'd0 && partial_word == 24'd0)
    else $error("word state not cleared after block end");

  a_writeback: assert property (@(posedge clk) disable iff (rst)
    wb_now |=> running_hash == $past(done.hash))
    else $error("block result not written to running hash");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done.valid && done.last && adv))
    else $error("result presented without a finished message");
`endif

endmodule

>>> tb/super_fast_hash_blocked_unit_tb.sv
// ----------------------------------------------------------------------------
// super_fast_hash_blocked_unit_tb
// Self-checking bench for the blocked byte-stream hash unit. Bytes are sent
// in directed and random messages, with both sides idling in random bursts
// while idling is enabled. A predictor in the bench tracks the running hash,
// the partial word and the block count, and each hash that leaves the unit is
// checked in order against the hashes that it has predicted.
// ----------------------------------------------------------------------------
module super_fast_hash_blocked_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic [30:0] message_length = 31'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] hash_value;

  logic        idle_on = 1'b1;
  int          stall_left = 0;
  int          bytes_sent = 0;
  int          mismatches = 0;

  // Predicted state of the hash.
  logic [31:0] run_hash = 32'd0;
  logic [23:0] word_bytes = 24'd0;
  logic [1:0]  word_fill = 2'd0;
  int          block_fill = 0;

  logic [31:0] hash_expected[$];
  logic [31:0] hash_want;

  super_fast_hash_blocked_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .first_byte(first_byte),
    .last_byte(last_byte),
    .message_length(message_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hash_value(hash_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] round_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] x;
    x = h + {16'h0000, w[15:0]};
    x = (x << 16) ^ (({16'h0000, w[31:16]} << 11) ^ x);
    return x + (x >> 11);
  endfunction

  function automatic logic [31:0] fold_tail(input logic [31:0] h, input logic [23:0] w,
                                            input logic [1:0] n);
    logic [31:0] x;
    x = h;
    case (n)
      2'd3: begin
        x = h + {16'h0000, w[15:0]};
        x = x ^ (x << 16);
        x = x ^ ({{24{w[23]}}, w[23:16]} << 18);
        x = x + (x >> 11);
      end
      2'd2: begin
        x = h + {16'h0000, w[15:0]};
        x = x ^ (x << 11);
        x = x + (x >> 17);
      end
      2'd1: begin
        x = h + {{24{w[7]}}, w[7:0]};
        x = x ^ (x << 10);
        x = x + (x >> 1);
      end
      default: x = h;
    endcase
    return x;
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h << 3);
    x = x + (x >> 5);
    x = x ^ (x << 4);
    x = x + (x >> 17);
    x = x ^ (x << 25);
    return x + (x >> 6);
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                              input logic [30:0] len);
    if (is_first) begin
      run_hash = {1'b0, len};
      word_bytes = 24'd0;
      word_fill = 2'd0;
      block_fill = 0;
    end
    if (word_fill == 2'd3) begin
      run_hash = round_word(run_hash, {b, word_bytes});
      word_bytes = 24'd0;
      word_fill = 2'd0;
    end else begin
      word_bytes = word_bytes | ({16'h0000, b} << (8 * word_fill));
      word_fill = word_fill + 2'd1;
    end
    if (block_fill + 1 >= sfhb_pkg::BLOCK_BYTES || is_last) begin
      run_hash = scramble(fold_tail(run_hash, word_bytes, word_fill));
      word_bytes = 24'd0;
      word_fill = 2'd0;
      block_fill = 0;
    end else begin
      block_fill = block_fill + 1;
    end
    if (is_last) hash_expected.push_back(run_hash);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                           input logic [30:0] len);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= is_first;
    last_byte <= is_last;
    message_length <= len;
    predict_byte(b, is_first, is_last, len);
    bytes_sent++;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // A negative fill value gives random bytes.
  task automatic send_message(input int n, input logic [30:0] seed, input bit with_first,
                              input bit with_last, input int fill);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      send_byte(b, with_first && i == 0, with_last && i == n - 1,
                (i == 0) ? seed : 31'($urandom));
    end
  endtask

  function automatic logic [30:0] pick_seed(input int n);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 31'(n);
    if (pick < 8) return 31'($urandom);
    if (pick == 8) return 31'd0;
    return 31'h7FFF_FFFF;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s: expected %08h, got %08h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic test_missing_first();
    send_byte(8'h5A, 1'b0, 1'b0, 31'($urandom));
    send_byte(8'hA5, 1'b0, 1'b1, 31'($urandom));
    send_byte(8'h3C, 1'b0, 1'b1, 31'($urandom));
  endtask

  task automatic test_seed_extremes();
    send_message(1, 31'd0, 1, 1, 8'h00);
    send_message(1, 31'h7FFF_FFFF, 1, 1, 8'hFF);
    send_message(1, 31'd1, 1, 1, 8'h80);
    send_message(3, 31'd1000, 1, 1, 8'h7F);
  endtask

  task automatic test_tail_lengths();
    send_message(2, 31'd2, 1, 1, 8'hFF);
    send_message(3, 31'd3, 1, 1, 8'hFF);
    send_message(4, 31'd4, 1, 1, 8'h80);
    send_message(5, 31'd5, 1, 1, 8'h80);
  endtask

  task automatic random_messages(input int target);
    int stop_at;
    int pick;
    int n;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      if (pick < 80) begin
        send_message(n, pick_seed(n), 1, 1, -1);
      end else if (pick < 88) begin
        send_message($urandom_range(1, 8), 31'($urandom), 0, 1, -1);
      end else if (pick < 94) begin
        send_message($urandom_range(1, 8), pick_seed(n), 1, 0, -1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 31'($urandom));
      end
    end
  endtask

  task automatic test_random_messages();
    for (int i = 0; i < 16; i++) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      random_messages(100);
    end
  endtask

  task automatic test_no_idle();
    idle_on <= 1'b0;
    random_messages(300);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (hash_expected.size() == 0) begin
        report_mismatch("hash with no message pending", 32'd0, hash_value);
      end else begin
        hash_want = hash_expected.pop_front();
        if (hash_value !== hash_want) report_mismatch("hash_value", hash_want, hash_value);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_missing_first();
    test_seed_extremes();
    test_tail_lengths();
    test_random_messages();
    test_no_idle();
    in_valid <= 1'b0;
    while (hash_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sfhb_pkg.sv
rtl/core/sfhb_finish.sv
rtl/core/super_fast_hash_blocked_unit.sv
tb/super_fast_hash_blocked_unit_tb.sv
